/* design/oat_pkg.sv */
package oat_pkg;

   typedef enum logic [1:0] {
      MODE_UPDATE = 2'd0,
      MODE_INSERT = 2'd1,
      MODE_SEARCH = 2'd2,
      MODE_REMOVE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_BAD_POS   = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_INS_RD,
      S_INS_WR,
      S_SRCH,
      S_SRCH_WAIT,
      S_SRCH_FIN,
      S_RM_SCAN,
      S_RM_WAIT,
      S_RM_RD,
      S_RM_WR
   } state_type;

   typedef struct packed {
      logic load;
      logic upd_write;
      logic emit_bad;
      logic emit_full;
      logic emit_nf;
      logic ins_start;
      logic ins_read;
      logic ins_move;
      logic ins_place;
      logic scan_start;
      logic scan_read;
      logic search_cmp;
      logic search_fin;
      logic rm_capture;
      logic rm_read;
      logic rm_move;
      logic rm_done;
   } cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     upd_ok;
      logic     ins_full;
      logic     ins_ok;
      logic     count_zero;
      logic     hit;
      logic     idx_last;
      logic     at_pos;
   } sts_type;

endpackage

/* design/ordered_array_table.sv */
// Ordered table of up to DEPTH signed 32-bit entries held in a RAM with one
// write port and one registered read port, with one request in flight at a
// time: start is taken only while busy is low. Every result appears for exactly
// one cycle with rsp_valid high and cannot be stalled, so the receiver must take
// it in that cycle. An update writes its entry directly, and a rejected request
// is answered without touching the RAM. An insert moves each entry from the end
// of the table back to the position up by one place and then writes the new
// value there. A search reads every entry and reports its matches at most one
// per cycle. A remove scans for the first matching entry, reports not found if
// there is none, and otherwise moves each later entry down by one place. The
// read-then-write of each moved entry through the one RAM port pair sets the
// shift time, and the one read per cycle sets the scan time.
module ordered_array_table #(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic [6:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_location,
   output logic [6:0]         rsp_entry_count,
   output logic               rsp_last
);

   oat_pkg::cmd_type cmd;
   oat_pkg::sts_type sts;

   oat_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy (busy),
      .sts  (sts),
      .cmd  (cmd)
   );

   oat_dp #(
      .DEPTH(DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_mode       (req_mode),
      .req_position   (req_position),
      .req_value      (req_value),
      .cmd            (cmd),
      .sts            (sts),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_location   (rsp_location),
      .rsp_entry_count(rsp_entry_count),
      .rsp_last       (rsp_last)
   );

endmodule

/* design/oat_ram.sv */
module oat_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/oat_ctrl.sv */
module oat_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  oat_pkg::sts_type sts,
   output oat_pkg::cmd_type cmd
);

   oat_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oat_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         oat_pkg::S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = oat_pkg::S_EXEC;
            end
         end
         oat_pkg::S_EXEC: begin
            state_in = oat_pkg::S_IDLE;
            case (sts.mode)
               oat_pkg::MODE_UPDATE: begin
                  if (sts.upd_ok) begin
                     cmd.upd_write = 1'b1;
                  end else begin
                     cmd.emit_bad = 1'b1;
                  end
               end
               oat_pkg::MODE_INSERT: begin
                  if (sts.ins_full) begin
                     cmd.emit_full = 1'b1;
                  end else if (!sts.ins_ok) begin
                     cmd.emit_bad = 1'b1;
                  end else begin
                     cmd.ins_start = 1'b1;
                     state_in      = oat_pkg::S_INS_RD;
                  end
               end
               oat_pkg::MODE_SEARCH: begin
                  if (sts.count_zero) begin
                     cmd.emit_nf = 1'b1;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = oat_pkg::S_SRCH;
                  end
               end
               oat_pkg::MODE_REMOVE: begin
                  if (sts.count_zero) begin
                     cmd.emit_nf = 1'b1;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = oat_pkg::S_RM_SCAN;
                  end
               end
               default: begin
                  cmd.emit_bad = 1'b1;
               end
            endcase
         end
         oat_pkg::S_INS_RD: begin
            if (sts.at_pos) begin
               cmd.ins_place = 1'b1;
               state_in      = oat_pkg::S_IDLE;
            end else begin
               cmd.ins_read = 1'b1;
               state_in     = oat_pkg::S_INS_WR;
            end
         end
         oat_pkg::S_INS_WR: begin
            cmd.ins_move = 1'b1;
            state_in     = oat_pkg::S_INS_RD;
         end
         oat_pkg::S_SRCH: begin
            cmd.scan_read  = 1'b1;
            cmd.search_cmp = 1'b1;
            if (sts.idx_last) begin
               state_in = oat_pkg::S_SRCH_WAIT;
            end
         end
         oat_pkg::S_SRCH_WAIT: begin
            cmd.search_cmp = 1'b1;
            state_in       = oat_pkg::S_SRCH_FIN;
         end
         oat_pkg::S_SRCH_FIN: begin
            cmd.search_fin = 1'b1;
            state_in       = oat_pkg::S_IDLE;
         end
         oat_pkg::S_RM_SCAN: begin
            if (sts.hit) begin
               cmd.rm_capture = 1'b1;
               state_in       = oat_pkg::S_RM_RD;
            end else begin
               cmd.scan_read = 1'b1;
               if (sts.idx_last) begin
                  state_in = oat_pkg::S_RM_WAIT;
               end
            end
         end
         oat_pkg::S_RM_WAIT: begin
            if (sts.hit) begin
               cmd.rm_capture = 1'b1;
               state_in       = oat_pkg::S_RM_RD;
            end else begin
               cmd.emit_nf = 1'b1;
               state_in    = oat_pkg::S_IDLE;
            end
         end
         oat_pkg::S_RM_RD: begin
            if (sts.idx_last) begin
               cmd.rm_done = 1'b1;
               state_in    = oat_pkg::S_IDLE;
            end else begin
               cmd.rm_read = 1'b1;
               state_in    = oat_pkg::S_RM_WR;
            end
         end
         oat_pkg::S_RM_WR: begin
            cmd.rm_move = 1'b1;
            state_in    = oat_pkg::S_RM_RD;
         end
         default: begin
            state_in = oat_pkg::S_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != oat_pkg::S_IDLE);

endmodule

/* design/oat_dp.sv */
module oat_dp #(
   parameter int DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         req_mode,
   input  logic [6:0]         req_position,
   input  logic signed [31:0] req_value,
   input  oat_pkg::cmd_type   cmd,
   output oat_pkg::sts_type   sts,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_location,
   output logic [6:0]         rsp_entry_count,
   output logic               rsp_last
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   oat_pkg::mode_type  mode_ff;
   logic [6:0]         pos_ff;
   logic signed [31:0] value_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] index_ff, index_in;
   logic          cmp_valid_ff;
   logic [CW-1:0] cmp_loc_ff, cmp_loc_in;
   logic [CW-1:0] pend_ff, pend_in;
   logic          have_pend_ff, have_pend_in;

   logic          rsp_valid_ff;
   logic [1:0]    rsp_status_ff;
   logic [6:0]    rsp_location_ff;
   logic [6:0]    rsp_entry_count_ff;
   logic          rsp_last_ff;

   logic                emit;
   oat_pkg::status_type e_status;
   logic [6:0]          e_loc;
   logic                e_last;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic [AW-1:0] rd_addr;
   logic [31:0]   rd_data;

   logic [7:0] pos8;
   logic [7:0] cnt8;
   logic [7:0] idx8;
   logic       hit;

   oat_ram #(
      .WIDTH(32),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign pos8 = {1'b0, pos_ff};
   assign cnt8 = 8'(count_ff);
   assign idx8 = 8'(index_ff);
   assign hit  = cmp_valid_ff && (rd_data == value_ff);

   assign sts.mode       = mode_ff;
   assign sts.upd_ok     = (pos_ff != 7'd0) && (pos8 <= cnt8);
   assign sts.ins_full   = (count_ff == CW'(DEPTH));
   assign sts.ins_ok     = (pos_ff != 7'd0) && (pos8 <= cnt8 + 8'd1);
   assign sts.count_zero = (count_ff == '0);
   assign sts.hit        = hit;
   assign sts.idx_last   = (idx8 + 8'd1 == cnt8);
   assign sts.at_pos     = (idx8 + 8'd1 == pos8);

   always_comb begin
      if (cmd.ins_read) begin
         rd_addr = index_ff - AW'(1);
      end else if (cmd.rm_read) begin
         rd_addr = index_ff + AW'(1);
      end else begin
         rd_addr = index_ff;
      end

      wr_en   = 1'b0;
      wr_addr = index_ff;
      wr_data = rd_data;
      if (cmd.upd_write) begin
         wr_en   = 1'b1;
         wr_addr = AW'(pos_ff - 7'd1);
         wr_data = value_ff;
      end else if (cmd.ins_place) begin
         wr_en   = 1'b1;
         wr_data = value_ff;
      end else if (cmd.ins_move || cmd.rm_move) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.ins_place) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.rm_done) begin
         count_in = count_ff - CW'(1);
      end

      index_in = index_ff;
      if (cmd.ins_start) begin
         index_in = count_ff[AW-1:0];
      end else if (cmd.ins_move) begin
         index_in = index_ff - AW'(1);
      end else if (cmd.scan_start) begin
         index_in = '0;
      end else if (cmd.rm_capture) begin
         index_in = AW'(cmp_loc_ff - CW'(1));
      end else if (cmd.scan_read || cmd.rm_move) begin
         index_in = index_ff + AW'(1);
      end

      cmp_loc_in = CW'(index_ff) + CW'(1);

      pend_in      = pend_ff;
      have_pend_in = have_pend_ff;
      if (cmd.scan_start) begin
         have_pend_in = 1'b0;
      end else if ((cmd.search_cmp && hit) || cmd.rm_capture) begin
         pend_in      = cmp_loc_ff;
         have_pend_in = 1'b1;
      end
   end

   always_comb begin
      emit     = 1'b0;
      e_status = oat_pkg::ST_OK;
      e_loc    = 7'd0;
      e_last   = 1'b1;
      if (cmd.upd_write || cmd.ins_place) begin
         emit  = 1'b1;
         e_loc = pos_ff;
      end else if (cmd.emit_bad) begin
         emit     = 1'b1;
         e_status = oat_pkg::ST_BAD_POS;
      end else if (cmd.emit_full) begin
         emit     = 1'b1;
         e_status = oat_pkg::ST_FULL;
      end else if (cmd.emit_nf) begin
         emit     = 1'b1;
         e_status = oat_pkg::ST_NOT_FOUND;
      end else if (cmd.rm_done) begin
         emit  = 1'b1;
         e_loc = 7'(pend_ff);
      end else if (cmd.search_cmp && hit && have_pend_ff) begin
         emit   = 1'b1;
         e_loc  = 7'(pend_ff);
         e_last = 1'b0;
      end else if (cmd.search_fin) begin
         emit = 1'b1;
         if (have_pend_ff) begin
            e_loc = 7'(pend_ff);
         end else begin
            e_status = oat_pkg::ST_NOT_FOUND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         have_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         cmp_valid_ff <= cmd.scan_read;
         have_pend_ff <= have_pend_in;
         rsp_valid_ff <= emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= oat_pkg::mode_type'(req_mode);
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
      index_ff   <= index_in;
      cmp_loc_ff <= cmp_loc_in;
      pend_ff    <= pend_in;
      if (emit) begin
         rsp_status_ff      <= e_status;
         rsp_location_ff    <= e_loc;
         rsp_entry_count_ff <= 7'(count_in);
         rsp_last_ff        <= e_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_location    = rsp_location_ff;
   assign rsp_entry_count = rsp_entry_count_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
